// ----- src/qte_pkg.sv -----
// Shared widths, constants, types and the CORDIC angle step function for the
// quaternion to Euler angle core. No dependencies.
package qte_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int SQRT_STEPS   = 32;

   localparam int QW  = 16;   // quaternion component
   localparam int PW  = 32;   // 16x16 product
   localparam int SW  = 35;   // sums of products
   localparam int NW  = 33;   // squared norm
   localparam int RW  = 32;   // square root and asin operands
   localparam int VW  = 64;   // square root radicand
   localparam int RMW = 36;   // square root remainder
   localparam int CW  = 58;   // CORDIC x / y
   localparam int ZW  = 35;   // CORDIC angle, 2^-30 rad
   localparam int MW  = 32;   // clamped angle magnitude
   localparam int DW  = 31;   // degree multiplier
   localparam int XW  = MW + DW;

   localparam int PRESCALE_SH = 20;
   localparam int RAD_SH      = 17;
   localparam int DEG_SH      = 48;

   localparam logic signed [ZW-1:0] ANG_PI      = 35'sd3373259426;
   localparam logic signed [ZW-1:0] ANG_HALF_PI = 35'sd1686629713;
   localparam logic [DW-1:0]        DEG_MULT    = 31'd1922527338;

   typedef logic signed [CW-1:0] cvec_type;
   typedef logic signed [ZW-1:0] zang_type;
   typedef logic signed [SW-1:0] sum_type;

   typedef struct packed {
      cvec_type x;
      cvec_type y;
      zang_type z;
      logic     zero;
   } cord_type;

   typedef struct packed {
      logic sat;
      logic neg;
      logic zero;
   } pflag_type;

   typedef struct packed {
      cord_type yaw;
      cord_type pitch;
      cord_type roll;
   } trio_type;

   // travels alongside the square root
   typedef struct packed {
      cord_type      yaw;
      cord_type      roll;
      logic [RW-1:0] pa;
      pflag_type     pf;
   } side_type;

   localparam zang_type ATAN_TAB [12] = '{
      35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
      35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
      35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288
   };

   function automatic zang_type atan_step(input logic [STEP_W-1:0] i);
      int idx;
      zang_type r;
      idx = int'(i);
      if (idx < 12) begin
         r = ATAN_TAB[idx];
      end else if (idx <= 30) begin
         r = zang_type'(1) <<< (30 - idx);
      end else begin
         r = '0;
      end
      return r;
   endfunction

endpackage

// ----- src/qte_channels.sv -----
// Handshake channels of the quaternion to Euler angle core: request,
// response and control register write. Depends on qte_pkg.
interface qte_req_if;
   import qte_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [QW-1:0] quat_real;
   logic signed [QW-1:0] quat_i;
   logic signed [QW-1:0] quat_j;
   logic signed [QW-1:0] quat_k;
   modport source (output valid, quat_real, quat_i, quat_j, quat_k, input ready);
   modport sink   (input valid, quat_real, quat_i, quat_j, quat_k, output ready);
endinterface

interface qte_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] yaw_angle;
   logic signed [14:0] pitch_angle;
   logic signed [15:0] roll_angle;
   modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
   modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface qte_csr_if;
   logic valid;
   logic ready;
   logic degree_mode;
   modport source (output valid, degree_mode, input ready);
   modport sink   (input valid, degree_mode, output ready);
endinterface

// ----- src/qte_sqrt_cell.sv -----
// One digit of the pipelined integer square root: two radicand bits in,
// one root bit out. Depends on qte_pkg.
module qte_sqrt_cell import qte_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           vld_in,
   input  logic [VW-1:0]  rad_in,
   input  logic [RMW-1:0] rem_in,
   input  logic [RW-1:0]  root_in,
   input  side_type       side_in,
   output logic           vld_out,
   output logic [VW-1:0]  rad_out,
   output logic [RMW-1:0] rem_out,
   output logic [RW-1:0]  root_out,
   output side_type       side_out
);

   logic           vld_ff;
   logic [VW-1:0]  rad_ff, rad_in_n;
   logic [RMW-1:0] rem_ff, rem_in_n;
   logic [RW-1:0]  root_ff, root_in_n;
   side_type       side_ff;
   logic [RMW-1:0] rem_sh, trial;

   always_comb begin
      rem_sh   = {rem_in[RMW-3:0], rad_in[VW-1 -: 2]};
      trial    = {{(RMW-RW-2){1'b0}}, root_in, 2'b01};
      rad_in_n = rad_in << 2;
      if (rem_sh >= trial) begin
         rem_in_n  = rem_sh - trial;
         root_in_n = {root_in[RW-2:0], 1'b1};
      end else begin
         rem_in_n  = rem_sh;
         root_in_n = {root_in[RW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in_n;
         rem_ff  <= rem_in_n;
         root_ff <= root_in_n;
         side_ff <= side_in;
      end
   end

   assign vld_out  = vld_ff;
   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign side_out = side_ff;

endmodule

// ----- src/qte_cordic_cell.sv -----
// One vectoring CORDIC iteration applied to the yaw, pitch and roll vectors
// side by side. Depends on qte_pkg.
module qte_cordic_cell import qte_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [STEP_W-1:0] step,
   input  logic              vld_in,
   input  trio_type          trio_in,
   input  pflag_type         pf_in,
   output logic              vld_out,
   output trio_type          trio_out,
   output pflag_type         pf_out
);

   logic      vld_ff;
   trio_type  trio_ff, trio_in_n;
   pflag_type pf_ff;

   function automatic cord_type rotate(input cord_type c, input logic [STEP_W-1:0] i);
      cvec_type dx, dy;
      zang_type ang;
      cord_type r;
      dx  = c.y >>> i;
      dy  = c.x >>> i;
      ang = atan_step(i);
      r   = c;
      if (!c.y[CW-1]) begin
         r.x = c.x + dx;
         r.y = c.y - dy;
         r.z = c.z + ang;
      end else begin
         r.x = c.x - dx;
         r.y = c.y + dy;
         r.z = c.z - ang;
      end
      return r;
   endfunction

   always_comb begin
      trio_in_n.yaw   = rotate(trio_in.yaw, step);
      trio_in_n.pitch = rotate(trio_in.pitch, step);
      trio_in_n.roll  = rotate(trio_in.roll, step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trio_ff <= trio_in_n;
         pf_ff   <= pf_in;
      end
   end

   assign vld_out  = vld_ff;
   assign trio_out = trio_ff;
   assign pf_out   = pf_ff;

endmodule

// ----- src/quaternion_to_euler_angles_core.sv -----
// Quaternion to yaw / pitch / roll. Fully pipelined: one request per cycle unless
// stalled; 6 front stages, 32 square root
// cells, CORDIC_STEPS CORDIC cells, 3 conversion stages incl. output register.
// The whole pipe stalls only while the output register holds an untaken result.
// Synchronous reset clears valids and sets degree mode.
module quaternion_to_euler_angles_core import qte_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   qte_req_if.sink    req_ch,
   qte_rsp_if.source  rsp_ch,
   qte_csr_if.sink    csr_ch
);

   logic adv;
   logic mode_ff;

   // stage 1: inputs
   logic                 s1_vld_ff;
   logic signed [QW-1:0] s1_r_ff, s1_i_ff, s1_j_ff, s1_k_ff;
   // stage 2: products
   logic                 s2_vld_ff;
   logic signed [PW-1:0] s2_rr_ff, s2_ii_ff, s2_jj_ff, s2_kk_ff, s2_ij_ff;
   logic signed [PW-1:0] s2_kr_ff, s2_jk_ff, s2_ir_ff, s2_jr_ff, s2_ik_ff;
   // stage 3: sums
   logic                 s3_vld_ff;
   sum_type              s3_yy_ff, s3_yx_ff, s3_ry_ff, s3_rx_ff, s3_h_ff;
   sum_type              s3_yy_in, s3_yx_in, s3_ry_in, s3_rx_in, s3_h_in, s3_n_sum;
   logic [NW-1:0]        s3_n_ff;
   // stage 4: asin operands, vector set-up
   logic                 s4_vld_ff;
   side_type             s4_side_ff, s4_side_in;
   logic [RW-1:0]        s4_n_ff, s4_n_in;
   sum_type              s4_habs;
   logic [NW-1:0]        s4_a;
   // stage 5/6: radicand
   logic                 s5_vld_ff, s6_vld_ff;
   side_type             s5_side_ff, s6_side_ff;
   logic [VW-1:0]        s5_nn_ff, s5_aa_ff, s6_v_ff;

   // square root chain
   logic                 sq_vld  [SQRT_STEPS+1];
   logic [VW-1:0]        sq_rad  [SQRT_STEPS+1];
   logic [RMW-1:0]       sq_rem  [SQRT_STEPS+1];
   logic [RW-1:0]        sq_root [SQRT_STEPS+1];
   side_type             sq_side [SQRT_STEPS+1];

   // CORDIC chain
   logic                 cd_vld  [CORDIC_STEPS+1];
   trio_type             cd_trio [CORDIC_STEPS+1];
   pflag_type            cd_pf   [CORDIC_STEPS+1];

   // conversion
   logic                 f1_vld_ff, f2_vld_ff;
   logic [MW-1:0]        f1_mag_ff [3];
   logic [MW-1:0]        f1_mag_in [3];
   logic                 f1_neg_ff [3];
   logic                 f1_neg_in [3];
   zang_type             fz [3];
   logic [MW-1:0]        f2_mag_ff [3];
   logic [XW-1:0]        f2_prod_ff [3];
   logic                 f2_neg_ff [3];
   logic [15:0]          f3_r [3];
   logic [15:0]          f3_s [3];

   logic                 rsp_vld_ff;
   logic signed [15:0]   rsp_yaw_ff, rsp_roll_ff;
   logic signed [14:0]   rsp_pitch_ff;

   function automatic cord_type cord_init(input sum_type y, input sum_type x);
      cvec_type xs, ys;
      cord_type c;
      xs     = CW'(x) <<< PRESCALE_SH;
      ys     = CW'(y) <<< PRESCALE_SH;
      c.zero = (x == '0) && (y == '0);
      if (x[SW-1]) begin
         c.z = y[SW-1] ? -ANG_PI : ANG_PI;
         c.x = -xs;
         c.y = -ys;
      end else begin
         c.z = '0;
         c.x = xs;
         c.y = ys;
      end
      return c;
   endfunction

   function automatic logic [MW-1:0] clamp_mag(input zang_type z, input zang_type lim);
      zang_type m;
      m = z[ZW-1] ? -z : z;
      if (m > lim) begin
         m = lim;
      end
      return m[MW-1:0];
   endfunction

   assign adv          = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_ch.valid) begin
         mode_ff <= csr_ch.degree_mode;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         f1_vld_ff  <= 1'b0;
         f2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff  <= req_ch.valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         s5_vld_ff  <= s4_vld_ff;
         s6_vld_ff  <= s5_vld_ff;
         f1_vld_ff  <= cd_vld[CORDIC_STEPS];
         f2_vld_ff  <= f1_vld_ff;
         rsp_vld_ff <= f2_vld_ff;
      end
   end

   always_comb begin
      s3_yy_in = (SW'(s2_ij_ff) + SW'(s2_kr_ff)) <<< 1;
      s3_yx_in = SW'(s2_ii_ff) - SW'(s2_jj_ff) - SW'(s2_kk_ff) + SW'(s2_rr_ff);
      s3_ry_in = (SW'(s2_jk_ff) + SW'(s2_ir_ff)) <<< 1;
      s3_rx_in = SW'(s2_kk_ff) + SW'(s2_rr_ff) - SW'(s2_ii_ff) - SW'(s2_jj_ff);
      s3_h_in  = SW'(s2_jr_ff) - SW'(s2_ik_ff);
      s3_n_sum = SW'(s2_ii_ff) + SW'(s2_jj_ff) + SW'(s2_kk_ff) + SW'(s2_rr_ff);
   end

   always_comb begin
      s4_habs            = s3_h_ff[SW-1] ? -s3_h_ff : s3_h_ff;
      s4_a               = {s4_habs[RW-1:0], 1'b0};
      s4_side_in.yaw     = cord_init(s3_yy_ff, s3_yx_ff);
      s4_side_in.roll    = cord_init(s3_ry_ff, s3_rx_ff);
      s4_side_in.pf.zero = (s3_n_ff == '0);
      s4_side_in.pf.sat  = (s3_n_ff != '0) && (s4_a >= s3_n_ff);
      s4_side_in.pf.neg  = s3_h_ff[SW-1];
      // full-scale norm: halve both, exact as the numerator is even
      if (s3_n_ff[NW-1]) begin
         s4_n_in       = s3_n_ff[NW-1:1];
         s4_side_in.pa = s4_a[NW-1:1];
      end else begin
         s4_n_in       = s3_n_ff[RW-1:0];
         s4_side_in.pa = s4_a[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_r_ff    <= req_ch.quat_real;
         s1_i_ff    <= req_ch.quat_i;
         s1_j_ff    <= req_ch.quat_j;
         s1_k_ff    <= req_ch.quat_k;
         s2_rr_ff   <= s1_r_ff * s1_r_ff;
         s2_ii_ff   <= s1_i_ff * s1_i_ff;
         s2_jj_ff   <= s1_j_ff * s1_j_ff;
         s2_kk_ff   <= s1_k_ff * s1_k_ff;
         s2_ij_ff   <= s1_i_ff * s1_j_ff;
         s2_kr_ff   <= s1_k_ff * s1_r_ff;
         s2_jk_ff   <= s1_j_ff * s1_k_ff;
         s2_ir_ff   <= s1_i_ff * s1_r_ff;
         s2_jr_ff   <= s1_j_ff * s1_r_ff;
         s2_ik_ff   <= s1_i_ff * s1_k_ff;
         s3_yy_ff   <= s3_yy_in;
         s3_yx_ff   <= s3_yx_in;
         s3_ry_ff   <= s3_ry_in;
         s3_rx_ff   <= s3_rx_in;
         s3_h_ff    <= s3_h_in;
         s3_n_ff    <= s3_n_sum[NW-1:0];
         s4_side_ff <= s4_side_in;
         s4_n_ff    <= s4_n_in;
         s5_nn_ff   <= VW'(s4_n_ff) * VW'(s4_n_ff);
         s5_aa_ff   <= VW'(s4_side_ff.pa) * VW'(s4_side_ff.pa);
         s5_side_ff <= s4_side_ff;
         s6_v_ff    <= s5_nn_ff - s5_aa_ff;
         s6_side_ff <= s5_side_ff;
      end
   end

   assign sq_vld[0]  = s6_vld_ff;
   assign sq_rad[0]  = s6_v_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_side[0] = s6_side_ff;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      qte_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .vld_in   (sq_vld[g]),
         .rad_in   (sq_rad[g]),
         .rem_in   (sq_rem[g]),
         .root_in  (sq_root[g]),
         .side_in  (sq_side[g]),
         .vld_out  (sq_vld[g+1]),
         .rad_out  (sq_rad[g+1]),
         .rem_out  (sq_rem[g+1]),
         .root_out (sq_root[g+1]),
         .side_out (sq_side[g+1])
      );
   end

   always_comb begin
      cd_vld[0]             = sq_vld[SQRT_STEPS];
      cd_trio[0].yaw        = sq_side[SQRT_STEPS].yaw;
      cd_trio[0].roll       = sq_side[SQRT_STEPS].roll;
      cd_trio[0].pitch.x    = cvec_type'({{(CW-RW){1'b0}}, sq_root[SQRT_STEPS]})
                              <<< PRESCALE_SH;
      cd_trio[0].pitch.y    = cvec_type'({{(CW-RW){1'b0}}, sq_side[SQRT_STEPS].pa})
                              <<< PRESCALE_SH;
      cd_trio[0].pitch.z    = '0;
      cd_trio[0].pitch.zero = sq_side[SQRT_STEPS].pf.zero || sq_side[SQRT_STEPS].pf.sat;
      cd_pf[0]              = sq_side[SQRT_STEPS].pf;
   end

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      qte_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .step     (STEP_W'(g)),
         .vld_in   (cd_vld[g]),
         .trio_in  (cd_trio[g]),
         .pf_in    (cd_pf[g]),
         .vld_out  (cd_vld[g+1]),
         .trio_out (cd_trio[g+1]),
         .pf_out   (cd_pf[g+1])
      );
   end

   // final angle selection and clamping; index 0 yaw, 1 pitch, 2 roll
   always_comb begin
      fz[0] = cd_trio[CORDIC_STEPS].yaw.zero  ? '0 : cd_trio[CORDIC_STEPS].yaw.z;
      fz[2] = cd_trio[CORDIC_STEPS].roll.zero ? '0 : cd_trio[CORDIC_STEPS].roll.z;
      if (cd_pf[CORDIC_STEPS].zero) begin
         fz[1] = '0;
      end else if (cd_pf[CORDIC_STEPS].sat) begin
         fz[1] = cd_pf[CORDIC_STEPS].neg ? -ANG_HALF_PI : ANG_HALF_PI;
      end else begin
         fz[1] = cd_pf[CORDIC_STEPS].neg ? -cd_trio[CORDIC_STEPS].pitch.z
                                         :  cd_trio[CORDIC_STEPS].pitch.z;
      end
      f1_mag_in[0] = clamp_mag(fz[0], ANG_PI);
      f1_mag_in[1] = clamp_mag(fz[1], ANG_HALF_PI);
      f1_mag_in[2] = clamp_mag(fz[2], ANG_PI);
      for (int n = 0; n < 3; n++) begin
         f1_neg_in[n] = fz[n][ZW-1];
      end
   end

   always_comb begin
      for (int n = 0; n < 3; n++) begin
         if (mode_ff) begin
            f3_r[n] = 16'((({1'b0, f2_prod_ff[n]}) + (64'd1 << (DEG_SH - 1))) >> DEG_SH);
         end else begin
            f3_r[n] = 16'(({1'b0, f2_mag_ff[n]} + (33'd1 << (RAD_SH - 1))) >> RAD_SH);
         end
         f3_s[n] = f2_neg_ff[n] ? -f3_r[n] : f3_r[n];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int n = 0; n < 3; n++) begin
            f1_mag_ff[n]  <= f1_mag_in[n];
            f1_neg_ff[n]  <= f1_neg_in[n];
            f2_mag_ff[n]  <= f1_mag_ff[n];
            f2_neg_ff[n]  <= f1_neg_ff[n];
            f2_prod_ff[n] <= XW'(f1_mag_ff[n]) * XW'(DEG_MULT);
         end
         rsp_yaw_ff   <= f3_s[0];
         rsp_pitch_ff <= f3_s[1][14:0];
         rsp_roll_ff  <= f3_s[2];
      end
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.yaw_angle   = rsp_yaw_ff;
   assign rsp_ch.pitch_angle = rsp_pitch_ff;
   assign rsp_ch.roll_angle  = rsp_roll_ff;

endmodule
